/* rtl/core/dual_port_pad_scan_controller_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the pad scan controller
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DUAL_PORT_PAD_SCAN_CONTROLLER_UNIT_ASSERT_SVH
`define DUAL_PORT_PAD_SCAN_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication
`define DPSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define DPSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/dpsc_pkg.sv */
// ----------------------------------------------------------------------------
// Pad scan controller package
// Shared constants, codes and structs of the two-port pad scan controller.
// ----------------------------------------------------------------------------
package dpsc_pkg;

  // Number of populated ports and number of address slots
  localparam int unsigned NUM_PORTS  = 2;
  localparam int unsigned SLOT_COUNT = 2;

  // Item modes
  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_FRAME = 2'd3
  } dpsc_mode_e;

  // Device kinds (code 3 acts as no device)
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_PAD   = 2'd1,
    KIND_MOUSE = 2'd2
  } dpsc_kind_e;

  // Configuration register indexes
  localparam logic [2:0] CFG_PORT0_KIND  = 3'd0;
  localparam logic [2:0] CFG_PORT1_KIND  = 3'd1;
  localparam logic [2:0] CFG_PAD_SIG     = 3'd2;
  localparam logic [2:0] CFG_MOUSE_SIG   = 3'd3;
  localparam logic [2:0] CFG_SCAN_DELAY  = 3'd4;

  // Configuration reset values
  localparam logic [3:0]  PAD_SIG_RST    = 4'hF;
  localparam logic [3:0]  MOUSE_SIG_RST  = 4'hD;
  localparam logic [15:0] SCAN_DELAY_RST = 16'd1536;

  // Gamepad toggle buttons
  localparam int unsigned TOGGLE_A_BIT = 12;
  localparam int unsigned TOGGLE_B_BIT = 14;

  // Mouse clamp and accumulator limits
  localparam logic signed [23:0] CLAMP_HI = 24'sd127;
  localparam logic signed [23:0] CLAMP_LO = -24'sd127;
  localparam logic signed [23:0] ACC_MAX  = 24'sh7FFFFF;
  localparam logic signed [23:0] ACC_MIN  = 24'sh800000;

  // Status register bit positions
  localparam int unsigned STS_SCAN_BIT  = 0;
  localparam int unsigned STS_LATCH_BIT = 3;

  // One item as seen by a port
  typedef struct packed {
    logic        step;
    dpsc_mode_e  mode;
    logic [7:0]  addr;
    logic [15:0] wdata;
    logic [15:0] ticks;
    logic        port;
    logic [15:0] pad;
    logic [15:0] dx;
    logic [15:0] dy;
    logic [7:0]  mbtn;
  } dpsc_cmd_t;

  // Per-port configuration view
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  pad_sig;
    logic [3:0]  mouse_sig;
    logic [15:0] delay;
    logic        clr;
  } dpsc_cfg_t;

  // Per-port result of an item
  typedef struct packed {
    logic        latched;
    logic        irq_set;
    logic [15:0] rdata;
  } dpsc_sts_t;

endpackage

/* rtl/core/dpsc_port.sv */
// ----------------------------------------------------------------------------
// Pad scan controller port
// State of one port: scan countdown, control, data latch and attached device.
// ----------------------------------------------------------------------------
module dpsc_port import dpsc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      port_id_i,
  input  dpsc_cmd_t cmd_i,
  input  dpsc_cfg_t cfg_i,
  output dpsc_sts_t sts_o
);

`include "dual_port_pad_scan_controller_unit_assert.svh"

  logic [15:0]        cd_q, cd_d;
  logic               lat_q, lat_d;
  logic [2:0]         ctrl_q, ctrl_d;
  logic [31:0]        dl_q, dl_d;
  logic [15:0]        pad_q, pad_d;
  logic [15:0]        prev_q, prev_d;
  logic [1:0]         tog_q, tog_d;
  logic signed [23:0] ax_q, ax_d;
  logic signed [23:0] ay_q, ay_d;
  logic [7:0]         mb_q, mb_d;

  logic               hit;
  logic [31:0]        sample;
  logic [7:0]         rx, ry;
  logic signed [23:0] ax_a, ay_a;
  logic               sel;
  logic               is_pad, is_mouse;
  logic [15:0]        rise;
  logic [1:0]         tog_n;

  // Saturating add of a 16-bit motion step
  function automatic logic signed [23:0] sat_add(logic signed [23:0] acc,
                                                 logic [15:0] delta);
    logic signed [24:0] sum;
    sum = {acc[23], acc} + {{9{delta[15]}}, delta};
    if (sum[24] != sum[23]) begin
      sat_add = sum[24] ? ACC_MIN : ACC_MAX;
    end else begin
      sat_add = sum[23:0];
    end
  endfunction

  // Clamp to +/-127, as 8-bit two's complement
  function automatic logic [7:0] clamp8(logic signed [23:0] v);
    if (v < CLAMP_LO) begin
      clamp8 = CLAMP_LO[7:0];
    end else if (v > CLAMP_HI) begin
      clamp8 = CLAMP_HI[7:0];
    end else begin
      clamp8 = v[7:0];
    end
  endfunction

  assign is_pad   = (cfg_i.kind == KIND_PAD);
  assign is_mouse = (cfg_i.kind == KIND_MOUSE);
  assign sel      = (cmd_i.addr[7] == port_id_i);

  // Device sample and countdown expiry
  assign hit = (cd_q != '0) && (cmd_i.ticks >= cd_q);
  assign rx  = clamp8(ax_q);
  assign ry  = clamp8(ay_q);

  always_comb begin
    sample = '0;
    if (is_pad) begin
      sample = {cfg_i.pad_sig, 12'd0, pad_q};
    end else if (is_mouse) begin
      sample = {cfg_i.mouse_sig, 4'd0, mb_q, rx, ry};
    end
  end

  // Frame update helpers for the gamepad
  assign rise  = (prev_q ^ cmd_i.pad) & cmd_i.pad;
  assign tog_n = tog_q ^ {rise[TOGGLE_B_BIT], rise[TOGGLE_A_BIT]};

  // Next state for one item
  always_comb begin
    cd_d   = cd_q;
    lat_d  = lat_q;
    ctrl_d = ctrl_q;
    dl_d   = dl_q;
    pad_d  = pad_q;
    prev_d = prev_q;
    tog_d  = tog_q;
    ax_a   = ax_q;
    ay_a   = ay_q;
    mb_d   = mb_q;
    sts_o  = '0;

    if (cmd_i.step) begin
      // time advance
      if (hit) begin
        cd_d      = '0;
        dl_d      = sample;
        lat_d     = 1'b1;
        ctrl_d[0] = 1'b0;
        sts_o.irq_set = 1'b1;
        if (is_mouse) begin
          ax_a = ax_q - {{16{rx[7]}}, rx};
          ay_a = ay_q - {{16{ry[7]}}, ry};
        end
      end else if (cd_q != '0) begin
        cd_d = cd_q - cmd_i.ticks;
      end

      case (cmd_i.mode)
        MODE_READ: begin
          if (sel) begin
            if (!cmd_i.addr[6] && !cmd_i.addr[1]) begin
              sts_o.rdata[STS_LATCH_BIT] = lat_d;
              sts_o.rdata[STS_SCAN_BIT]  = (cd_d != '0);
            end else if (cmd_i.addr[1]) begin
              sts_o.rdata = dl_d[31:16];
            end else begin
              sts_o.rdata = dl_d[15:0];
              lat_d       = 1'b0;
            end
          end
        end
        MODE_WRITE: begin
          if (sel && !cmd_i.addr[6]) begin
            if (cmd_i.wdata[0] && !ctrl_d[0]) begin
              cd_d  = cfg_i.delay;
              lat_d = 1'b0;
            end
            ctrl_d = cmd_i.wdata[2:0];
          end
        end
        MODE_FRAME: begin
          if (cmd_i.port == port_id_i) begin
            if (is_pad) begin
              tog_d  = tog_n;
              pad_d  = cmd_i.pad;
              pad_d[TOGGLE_A_BIT] = tog_n[0];
              pad_d[TOGGLE_B_BIT] = tog_n[1];
              prev_d = cmd_i.pad;
            end else if (is_mouse) begin
              ax_a = sat_add(ax_a, cmd_i.dx);
              ay_a = sat_add(ay_a, cmd_i.dy);
              mb_d = cmd_i.mbtn;
            end
          end
        end
        default: begin
        end
      endcase
    end

    ax_d = ax_a;
    ay_d = ay_a;

    // a write to the device kind drops the device state
    if (cfg_i.clr) begin
      pad_d  = '0;
      prev_d = '0;
      tog_d  = '0;
      ax_d   = '0;
      ay_d   = '0;
      mb_d   = '0;
    end

    sts_o.latched = lat_d;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cd_q   <= '0;
      lat_q  <= 1'b0;
      ctrl_q <= '0;
      dl_q   <= '0;
      pad_q  <= '0;
      prev_q <= '0;
      tog_q  <= '0;
      ax_q   <= '0;
      ay_q   <= '0;
      mb_q   <= '0;
    end else begin
      cd_q   <= cd_d;
      lat_q  <= lat_d;
      ctrl_q <= ctrl_d;
      dl_q   <= dl_d;
      pad_q  <= pad_d;
      prev_q <= prev_d;
      tog_q  <= tog_d;
      ax_q   <= ax_d;
      ay_q   <= ay_d;
      mb_q   <= mb_d;
    end
  end

  // Checks
  `DPSC_ASSERT_NEXT(a_latch_sample, cmd_i.step && hit, dl_q == $past(sample), "latch missed sample")
  `DPSC_ASSERT_NOW(a_cd_start, (cd_q == '0) && (cd_d != '0), cmd_i.step && (cmd_i.mode == MODE_WRITE), "countdown started without a write")
  `DPSC_ASSERT_NEXT(a_nodev_hold, !cfg_i.clr && !is_pad && !is_mouse, $stable(pad_q) && $stable(ax_q) && $stable(mb_q), "device state moved with no device")

endmodule

/* rtl/core/dual_port_pad_scan_controller_unit.sv */
// An input transfer is captured in the input register; the port state updates as
// the item moves on, and its result is offered from the result register.
// Throughput: one item per cycle while out_ready_i is high; the single-pass
// state update sets this. A stalled result holds the next item in the input
// register; in_ready_o drops only while both registers are full.
// Reset: rst_ni clears all state and both valid bits and restores config defaults.
// ----------------------------------------------------------------------------
// Pad scan controller top level
// Two-port pad scan peripheral with a bus item channel and a config port.
// ----------------------------------------------------------------------------
module dual_port_pad_scan_controller_unit import dpsc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [7:0]         address_i,
  input  logic               byte_access_i,
  input  logic [15:0]        write_data_i,
  input  logic [15:0]        elapsed_ticks_i,
  input  logic               port_i,
  input  logic [15:0]        pad_buttons_i,
  input  logic signed [15:0] mouse_dx_i,
  input  logic signed [15:0] mouse_dy_i,
  input  logic [7:0]         mouse_buttons_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        read_data_o,
  output logic               irq_o
);

  logic [SLOT_COUNT-1:0][1:0] kind_q;
  logic [3:0]                 pad_sig_q;
  logic [3:0]                 mouse_sig_q;
  logic [15:0]                delay_q;

  logic                       s1_valid_q;
  dpsc_cmd_t                  s1_q;
  logic                       byte_q;
  logic                       s1_go;

  dpsc_cmd_t                  cmd;
  dpsc_cfg_t [SLOT_COUNT-1:0] cfg;
  dpsc_sts_t [SLOT_COUNT-1:0] sts;

  logic                       irq_q, irq_d;
  logic [15:0]                rd_word, rd_d;
  logic                       out_valid_q;
  logic [15:0]                read_data_q;
  logic                       irq_out_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= '0;
      pad_sig_q   <= PAD_SIG_RST;
      mouse_sig_q <= MOUSE_SIG_RST;
      delay_q     <= SCAN_DELAY_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PORT0_KIND: kind_q[0]   <= cfg_wdata_i[1:0];
        CFG_PORT1_KIND: kind_q[1]   <= cfg_wdata_i[1:0];
        CFG_PAD_SIG:    pad_sig_q   <= cfg_wdata_i[3:0];
        CFG_MOUSE_SIG:  mouse_sig_q <= cfg_wdata_i[3:0];
        CFG_SCAN_DELAY: delay_q     <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Pipeline handshake: the input register moves on when the result slot frees
  assign s1_go      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q.step  <= 1'b1;
      s1_q.mode  <= dpsc_mode_e'(mode_i);
      s1_q.addr  <= address_i;
      s1_q.wdata <= write_data_i;
      s1_q.ticks <= elapsed_ticks_i;
      s1_q.port  <= port_i;
      s1_q.pad   <= pad_buttons_i;
      s1_q.dx    <= mouse_dx_i;
      s1_q.dy    <= mouse_dy_i;
      s1_q.mbtn  <= mouse_buttons_i;
      byte_q     <= byte_access_i;
    end
  end

  // Command to the ports: step marks a moving item, so an item updates state as it moves
  always_comb begin
    cmd      = s1_q;
    cmd.step = s1_go;
  end

  // Per-port slots
  for (genvar p = 0; p < SLOT_COUNT; p++) begin : g_port
    if (p < NUM_PORTS) begin : g_on
      always_comb begin
        cfg[p].kind      = kind_q[p];
        cfg[p].pad_sig   = pad_sig_q;
        cfg[p].mouse_sig = mouse_sig_q;
        cfg[p].delay     = delay_q;
        cfg[p].clr       = cfg_we_i && (cfg_index_i == 3'(p));
      end

      dpsc_port u_port (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .port_id_i (1'(p)),
        .cmd_i     (cmd),
        .cfg_i     (cfg[p]),
        .sts_o     (sts[p])
      );
    end else begin : g_off
      assign cfg[p] = '0;
      assign sts[p] = '0;
    end
  end

  // Read data and interrupt level
  always_comb begin
    rd_word = '0;
    for (int p = 0; p < SLOT_COUNT; p++) begin
      rd_word = rd_word | sts[p].rdata;
    end
    rd_d = rd_word;
    if (byte_q) begin
      rd_d = s1_q.addr[0] ? {8'd0, rd_word[15:8]} : {8'd0, rd_word[7:0]};
    end

    irq_d = irq_q;
    for (int p = 0; p < SLOT_COUNT; p++) begin
      irq_d = irq_d | sts[p].irq_set;
    end
    if ((s1_q.mode == MODE_READ) && !(sts[0].latched || sts[1].latched)) begin
      irq_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_q <= 1'b0;
    end else if (s1_go) begin
      irq_q <= irq_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      read_data_q <= rd_d;
      irq_out_q   <= irq_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;
  assign irq_o       = irq_out_q;

endmodule
